// File: rtl/pali_pkg.sv
// Shared types and constants of the polyline arc-length integrator.
// Holds the shared-unit operation codes, the sequencer control word and the
// fixed result widths; used by the top level and the sequencer.
`default_nettype none

package pali_pkg;

  localparam int LEN_W = 40;
  localparam int INT_W = 48;
  localparam int IDX_W = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = 40'hFF_FFFF_FFFF;
  localparam logic signed [INT_W-1:0] INT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [INT_W-1:0] INT_MIN = 48'sh8000_0000_0000;
  localparam logic [IDX_W-1:0] IDX_MAX = 16'hFFFF;
  localparam logic [INT_W:0] TERM_CLAMP = 49'h1_0000_0000_0000;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_SQ,
    OP_ROOT,
    OP_MUL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       ld;
    logic       run;
    logic       fin;
  } ctrl_t;

endpackage

`default_nettype wire

// File: rtl/polyline_arc_length_integrator.sv
// Top level of the polyline arc-length integrator: handshakes, line state,
// datapath registers and result register. Depends on pali_pkg, pali_ctrl
// and pali_addsub.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | pos_x, pos_y, pos_z, sample, line_start
//   out_    | output    | out_valid/out_stall | segment_length, arc_length,
//           |           |                     | running_integral, point_index
//
// An ordinary point keeps the block busy, once accepted, for three
// shift-add squares, a radix-4 root and a shift-add multiply, all one step a
// cycle through the shared adder. A line-start point goes straight to the
// finishing state. The next word is taken the cycle after the result is
// written to the output register, even if that result is still stalled.
// A stalled result holds the sequencer in its last cycle.
// Reset clears the line state to the origin with zero sums.
`default_nettype none

module polyline_arc_length_integrator
  import pali_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_sample,
  input  wire logic                          in_line_start,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic             [LEN_W-1:0]       out_segment_length,
  output logic             [LEN_W-1:0]       out_arc_length,
  output logic signed      [INT_W-1:0]       out_running_integral,
  output logic             [IDX_W-1:0]       out_point_index
);

  localparam int CW   = COORD_WIDTH;
  localparam int SQW  = 2 * CW + 2;
  localparam int RW   = CW + 1;
  localparam int REMW = CW + 4;
  localparam int PW   = LEN_W + CW + 1;
  localparam int AW   = (SQW > PW) ? SQW : PW;
  localparam int SW   = (RW > LEN_W) ? RW : LEN_W;
  localparam int TW   = PW - FRAC_BITS - 1;
  localparam int TXW  = (TW > INT_W + 1) ? TW : INT_W + 1;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
    logic signed [CW:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    abs_diff = d[CW] ? CW'(-d) : d[CW-1:0];
  endfunction

  ctrl_t ctrl;
  logic  busy;
  logic  in_fire;
  logic  hold;
  logic  fin_fire;

  logic [CW-1:0]        last_x_r, last_y_r, last_z_r, last_sample_r;
  logic [LEN_W-1:0]     length_sum_r;
  logic signed [INT_W-1:0] integral_sum_r;
  logic [IDX_W-1:0]     index_count_r;

  logic [CW-1:0]   dx_r, dy_r, dz_r;
  logic [CW:0]     mag_r;
  logic            neg_r;
  logic            start_r;
  logic [AW-1:0]   acc_r;
  logic [AW-1:0]   mcand_r;
  logic [CW:0]     mplier_r;
  logic [REMW-1:0] rem_r;
  logic [RW-1:0]   root_r;

  logic            out_valid_r;
  logic [LEN_W-1:0] out_seg_r, out_arc_r;
  logic signed [INT_W-1:0] out_int_r;
  logic [IDX_W-1:0] out_idx_r;

  logic [AW-1:0]   ua, ub, usum;
  logic            usub, ucout;
  logic [CW-1:0]   dsel;
  logic [REMW-1:0] remsh, trial;
  logic [SW-1:0]   rootx;
  logic [LEN_W-1:0] seg;
  logic [TXW-1:0]  tx;
  logic [INT_W:0]  tc;
  logic [LEN_W:0]  len_add;
  logic [LEN_W-1:0] length_sum_nxt;
  logic signed [INT_W+1:0] isum;
  logic signed [INT_W-1:0] integral_sum_nxt;
  logic [IDX_W-1:0] index_count_nxt;
  logic signed [CW:0] ssum;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = busy;
  assign hold     = out_valid_r && out_stall;
  assign fin_fire = ctrl.fin && !hold;

  pali_ctrl #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (in_fire && !in_line_start),
    .skip (in_fire && in_line_start),
    .hold (hold),
    .ctrl (ctrl),
    .busy (busy)
  );

  pali_addsub #(
    .W(AW)
  ) u_addsub (
    .a   (ua),
    .b   (ub),
    .sub (usub),
    .sum (usum),
    .cout(ucout)
  );

  assign remsh = {rem_r[REMW-3:0], acc_r[SQW-1:SQW-2]};
  assign trial = REMW'({root_r, 2'b01});
  assign ssum  = $signed({last_sample_r[CW-1], last_sample_r})
               + $signed({in_sample[CW-1], in_sample});

  always_comb begin
    unique case (ctrl.axis)
      AXIS_X:  dsel = dx_r;
      AXIS_Y:  dsel = dy_r;
      default: dsel = dz_r;
    endcase
  end

  always_comb begin
    ua   = '0;
    ub   = '0;
    usub = 1'b0;
    unique case (ctrl.op)
      OP_SQ, OP_MUL: begin
        ua = acc_r;
        ub = mplier_r[0] ? mcand_r : '0;
      end
      OP_ROOT: begin
        ua   = AW'(remsh);
        ub   = AW'(trial);
        usub = 1'b1;
      end
      default: begin
        ua = '0;
      end
    endcase
  end

  always_comb begin
    rootx = SW'(root_r);
    seg   = (rootx > SW'(LEN_MAX)) ? LEN_MAX : rootx[LEN_W-1:0];
    tx    = TXW'(acc_r[PW-1:FRAC_BITS+1]);
    tc    = (tx > TXW'(TERM_CLAMP)) ? TERM_CLAMP : tx[INT_W:0];

    len_add = {1'b0, length_sum_r} + {1'b0, seg};
    isum    = neg_r ? (INT_W+2)'(integral_sum_r) - $signed({1'b0, tc})
                    : (INT_W+2)'(integral_sum_r) + $signed({1'b0, tc});

    if (start_r) begin
      length_sum_nxt   = '0;
      integral_sum_nxt = '0;
      index_count_nxt  = '0;
    end else begin
      length_sum_nxt = len_add[LEN_W] ? LEN_MAX : len_add[LEN_W-1:0];
      priority if (isum > (INT_W+2)'(INT_MAX)) begin
        integral_sum_nxt = INT_MAX;
      end else if (isum < (INT_W+2)'(INT_MIN)) begin
        integral_sum_nxt = INT_MIN;
      end else begin
        integral_sum_nxt = isum[INT_W-1:0];
      end
      index_count_nxt = (index_count_r == IDX_MAX) ? IDX_MAX
                                                   : index_count_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r       <= '0;
      last_y_r       <= '0;
      last_z_r       <= '0;
      last_sample_r  <= '0;
      length_sum_r   <= '0;
      integral_sum_r <= '0;
      index_count_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        last_x_r      <= in_pos_x;
        last_y_r      <= in_pos_y;
        last_z_r      <= in_pos_z;
        last_sample_r <= in_sample;
      end
      if (fin_fire) begin
        length_sum_r   <= length_sum_nxt;
        integral_sum_r <= integral_sum_nxt;
        index_count_r  <= index_count_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dx_r    <= abs_diff(in_pos_x, last_x_r);
      dy_r    <= abs_diff(in_pos_y, last_y_r);
      dz_r    <= abs_diff(in_pos_z, last_z_r);
      neg_r   <= ssum[CW];
      mag_r   <= ssum[CW] ? (CW+1)'(-ssum) : ssum;
      start_r <= in_line_start;
      acc_r   <= '0;
    end else if (ctrl.ld) begin
      unique case (ctrl.op)
        OP_SQ: begin
          mcand_r  <= AW'(dsel);
          mplier_r <= {1'b0, dsel};
        end
        OP_ROOT: begin
          rem_r  <= '0;
          root_r <= '0;
        end
        OP_MUL: begin
          mcand_r  <= AW'(seg);
          mplier_r <= mag_r;
          acc_r    <= '0;
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end else if (ctrl.run) begin
      unique case (ctrl.op)
        OP_SQ, OP_MUL: begin
          acc_r    <= usum;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end
        OP_ROOT: begin
          acc_r <= acc_r << 2;
          if (ucout) begin
            rem_r  <= usum[REMW-1:0];
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= remsh;
            root_r <= {root_r[RW-2:0], 1'b0};
          end
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_seg_r <= start_r ? '0 : seg;
      out_arc_r <= length_sum_nxt;
      out_int_r <= integral_sum_nxt;
      out_idx_r <= index_count_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_segment_length   = out_seg_r;
  assign out_arc_length       = out_arc_r;
  assign out_running_integral = out_int_r;
  assign out_point_index      = out_idx_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("Block not busy after taking a word.");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.fin))
    else $error("Result appeared without a finishing cycle.");

  a_arc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && !start_r) |-> (length_sum_nxt >= length_sum_r))
    else $error("Arc length decreased within a line.");

endmodule

`default_nettype wire

// File: rtl/pali_addsub.sv
// Shared adder and subtractor of the integrator datapath.
// Plain W-bit add or subtract with carry out; no package dependency.
`default_nettype none

module pali_addsub #(
  parameter int W = 73
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic      [W-1:0] sum,
  output logic              cout
);

  // For a subtraction the carry out is high when a is not below b.
  assign {cout, sum} = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);

endmodule

`default_nettype wire

// File: rtl/pali_ctrl.sv
// Sequencer of the integrator: walks the square, root and multiply phases.
// Depends on pali_pkg for the operation codes and the control word.
`default_nettype none

module pali_ctrl
  import pali_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  go,
  input  wire logic  skip,
  input  wire logic  hold,
  output ctrl_t      ctrl,
  output logic       busy
);

  localparam int CNTW = $clog2(COORD_WIDTH + 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_FIN
  } state_t;

  state_t          state_r;
  op_t             op_r;
  logic [1:0]      axis_r;
  logic [CNTW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_IDLE;
      axis_r  <= AXIS_X;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            state_r <= S_LOAD;
            op_r    <= OP_SQ;
            axis_r  <= AXIS_X;
          end else if (skip) begin
            state_r <= S_FIN;
          end
        end
        S_LOAD: begin
          state_r <= S_RUN;
          if (op_r == OP_SQ) begin
            cnt_r <= CNTW'(COORD_WIDTH - 1);
          end else begin
            cnt_r <= CNTW'(COORD_WIDTH);
          end
        end
        S_RUN: begin
          if (cnt_r == '0) begin
            state_r <= S_LOAD;
            priority if (op_r == OP_SQ && axis_r != AXIS_Z) begin
              axis_r <= axis_r + 2'd1;
            end else if (op_r == OP_SQ) begin
              op_r <= OP_ROOT;
            end else if (op_r == OP_ROOT) begin
              op_r <= OP_MUL;
            end else begin
              state_r <= S_FIN;
            end
          end else begin
            cnt_r <= cnt_r - CNTW'(1);
          end
        end
        S_FIN: begin
          if (!hold) begin
            state_r <= S_IDLE;
            op_r    <= OP_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl.op   = op_r;
    ctrl.axis = axis_r;
    ctrl.ld   = (state_r == S_LOAD);
    ctrl.run  = (state_r == S_RUN);
    ctrl.fin  = (state_r == S_FIN);
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// File: verif/tb_polyline_arc_length_integrator.sv
// Self-checking testbench of polyline_arc_length_integrator: a queue-fed driver and a
// monitor that checks each result word against a line-state predictor kept in the bench.
// Depends on pali_pkg and the polyline_arc_length_integrator RTL.
`default_nettype none

module tb_polyline_arc_length_integrator;
  import pali_pkg::*;

  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int CALM_TAIL   = 50;

  localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] ONE   = 32'h0001_0000;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] s;
    logic               start;
    bit                 drain_first;
  } point_t;

  typedef struct {
    logic [LEN_W-1:0]        seg;
    logic [LEN_W-1:0]        arc;
    logic signed [INT_W-1:0] integ;
    logic [IDX_W-1:0]        idx;
  } line_res_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_pos_x = '0;
  logic signed [COORD_W-1:0] in_pos_y = '0;
  logic signed [COORD_W-1:0] in_pos_z = '0;
  logic signed [COORD_W-1:0] in_sample = '0;
  logic                      in_line_start = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [LEN_W-1:0]          out_segment_length;
  logic [LEN_W-1:0]          out_arc_length;
  logic signed [INT_W-1:0]   out_running_integral;
  logic [IDX_W-1:0]          out_point_index;

  point_t    point_queue[$];
  line_res_t line_results_due[$];
  point_t    cur_pt;

  logic [COORD_W-1:0]      prev_x = '0, prev_y = '0, prev_z = '0, prev_s = '0;
  logic [LEN_W-1:0]        length_acc = '0;
  logic signed [INT_W-1:0] integral_acc = '0;
  logic [IDX_W-1:0]        index_acc = '0;

  int   points_sent = 0;
  int   results_seen = 0;
  int   err_cnt = 0;
  int   quiet_cycles = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   send_pct = 20;
  int   stall_pct = 20;
  logic calm = 1'b0;

  polyline_arc_length_integrator u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pos_z            (in_pos_z),
    .in_sample           (in_sample),
    .in_line_start       (in_line_start),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_segment_length  (out_segment_length),
    .out_arc_length      (out_arc_length),
    .out_running_integral(out_running_integral),
    .out_point_index     (out_point_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [33:0] root_floor(logic [67:0] v);
    logic [33:0] r;
    logic [67:0] t;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = {34'd0, r | (34'd1 << b)};
      if (t * t <= v) r = r | (34'd1 << b);
    end
    return r;
  endfunction

  function automatic logic [67:0] axis_sq(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [67:0]      m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? {35'd0, ~d + 1'b1} : {35'd0, d};
    return m * m;
  endfunction

  function automatic line_res_t trace_point(point_t p);
    line_res_t        r;
    logic [LEN_W-1:0] seg;
    logic [LEN_W:0]   len_next;
    logic [COORD_W:0] ssum;
    logic [79:0]      segw;
    logic [79:0]      magw;
    logic [79:0]      term;
    logic signed [50:0] acc;
    logic signed [50:0] tw;
    seg = '0;
    if (p.start) begin
      length_acc   = '0;
      integral_acc = '0;
      index_acc    = '0;
    end else begin
      seg = {6'd0, root_floor(axis_sq(p.x, prev_x) + axis_sq(p.y, prev_y)
                              + axis_sq(p.z, prev_z))};
      len_next   = {1'b0, length_acc} + {1'b0, seg};
      length_acc = len_next[LEN_W] ? LEN_MAX : len_next[LEN_W-1:0];
      ssum = {prev_s[COORD_W-1], prev_s} + {p.s[COORD_W-1], p.s};
      segw = {40'd0, seg};
      magw = ssum[COORD_W] ? {47'd0, ~ssum + 1'b1} : {47'd0, ssum};
      term = (segw * magw) >> (FRAC_W + 1);
      if (term > (80'd1 << INT_W)) term = 80'd1 << INT_W;
      tw  = $signed({2'b00, term[48:0]});
      acc = integral_acc;
      acc = ssum[COORD_W] ? acc - tw : acc + tw;
      if (acc > INT_MAX) acc = INT_MAX;
      if (acc < INT_MIN) acc = INT_MIN;
      integral_acc = acc[INT_W-1:0];
      if (index_acc != IDX_MAX) index_acc = index_acc + 1'b1;
    end
    prev_x = p.x;
    prev_y = p.y;
    prev_z = p.z;
    prev_s = p.s;
    r.seg   = seg;
    r.arc   = length_acc;
    r.integ = integral_acc;
    r.idx   = index_acc;
    return r;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 4))
      0, 1:    return 0;
      2:       return 10;
      3:       return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(int kind);
    if (kind == 0) return COORD_W'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
    if (kind == 1) return $urandom;
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return '1;
      4:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_pt(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                        logic [COORD_W-1:0] s, logic start, bit drain_first);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.s = s;
    p.start = start;
    p.drain_first = drain_first;
    point_queue.insert(point_queue.size(), p);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h (word %0d)", what, got, want, results_seen);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    logic took;
    logic nxt_valid;
    took = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid && !took;
      if (took) begin
        line_results_due.insert(line_results_due.size(), trace_point(cur_pt));
        points_sent <= points_sent + 1;
        if (points_sent % 64 == 0) send_pct = pick_pct();
      end
      if (!nxt_valid && point_queue.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 99) < send_pct) begin
          send_gap = $urandom_range(0, 17);
        end else if (!point_queue[0].drain_first ||
                     (!took && points_sent == results_seen)) begin
          cur_pt = point_queue.pop_front();
          in_pos_x      <= cur_pt.x;
          in_pos_y      <= cur_pt.y;
          in_pos_z      <= cur_pt.z;
          in_sample     <= cur_pt.s;
          in_line_start <= cur_pt.start;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
      if (point_queue.size() <= CALM_TAIL) calm <= 1'b1;
    end
  end

  always @(posedge clk) begin
    line_res_t want;
    logic      nxt_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (results_seen % 64 == 0) stall_pct = pick_pct();
        if (line_results_due.size() == 0) begin
          report_mismatch("unexpected word, segment_length", out_segment_length, '0);
        end else begin
          want = line_results_due.pop_front();
          if (out_segment_length !== want.seg)
            report_mismatch("segment_length", out_segment_length, want.seg);
          if (out_arc_length !== want.arc)
            report_mismatch("arc_length", out_arc_length, want.arc);
          if (out_running_integral !== want.integ)
            report_mismatch("running_integral", out_running_integral, want.integ);
          if (out_point_index !== want.idx)
            report_mismatch("point_index", out_point_index, want.idx);
        end
      end
      nxt_stall = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 17);
        nxt_stall = 1'b1;
      end
      out_stall <= nxt_stall;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int kind;
    int len;
    add_pt(ONE, 2 * ONE, 2 * ONE, ONE, 1'b0, 1'b0);
    add_pt(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0, 1'b0);
    add_pt(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 1'b0);
    add_pt('0, '0, '0, '0, 1'b1, 1'b1);
    add_pt('0, '0, '0, C_MAX, 1'b0, 1'b0);
    add_pt(-ONE, '0, '0, -ONE, 1'b0, 1'b0);
    add_pt(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0, 1'b0);
    add_pt(C_MIN, C_MIN, C_MIN, C_MAX, 1'b0, 1'b0);
    add_pt(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0, 1'b0);
    add_pt(C_MIN, C_MIN, C_MIN, C_MAX, 1'b1, 1'b0);
    add_pt(C_MAX, C_MIN, C_MAX, C_MIN, 1'b0, 1'b0);
    add_pt(C_MIN, C_MAX, C_MIN, C_MIN, 1'b0, 1'b0);
    add_pt(C_MAX, C_MIN, C_MAX, C_MIN, 1'b0, 1'b0);
    add_pt(C_MIN, C_MAX, C_MIN, '0, 1'b0, 1'b0);
    add_pt(32'd1, '0, '0, 32'd1, 1'b1, 1'b0);
    add_pt('0, '0, '0, '1, 1'b0, 1'b0);
    add_pt('0, '1, '0, C_MAX, 1'b0, 1'b0);
    add_pt(C_MAX, '0, '0, C_MIN, 1'b0, 1'b0);
    add_pt(C_MIN, '0, '0, C_MIN, 1'b0, 1'b0);
    add_pt(32'd5, 32'd5, 32'd5, ONE, 1'b1, 1'b1);

    add_pt(C_MIN, C_MIN, C_MIN, $urandom, 1'b1, 1'b0);
    for (int i = 1; i < 160; i++) begin
      if (i % 2 == 1) add_pt(C_MAX, C_MAX, C_MAX, $urandom, 1'b0, 1'b0);
      else add_pt(C_MIN, C_MIN, C_MIN, $urandom, 1'b0, 1'b0);
    end

    while (point_queue.size() < 770) begin
      kind = $urandom_range(0, 9);
      kind = (kind < 5) ? 0 : (kind < 8) ? 1 : 2;
      len  = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
        add_pt(rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind),
               (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
               $urandom_range(0, 99) == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (point_queue.size() != 0 || in_valid);
    while (results_seen != points_sent) @(negedge clk);
    repeat (200) @(negedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
